### design/ini_text_tokenizer_core_assert.svh
// Assertion macros for the tokenizer checker.
`ifndef INI_TEXT_TOKENIZER_CORE_ASSERT_SVH
`define INI_TEXT_TOKENIZER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define ITT_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define ITT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/itt_pkg.sv
// Types, constants and helpers shared by the INI tokenizer modules.
`default_nettype none

package itt_pkg;

	localparam int MAX_LEN   = 256;
	localparam int LEN_W     = $clog2(MAX_LEN);
	localparam int CMP_W     = (LEN_W > 8) ? LEN_W : 8;
	localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(MAX_LEN - 1);

	localparam int RES_MAX   = 4;
	localparam int RES_IDX_W = 2;
	localparam int RES_CNT_W = 3;

	localparam logic [7:0] CH_COMMENT = 8'h3B;
	localparam logic [7:0] CH_OPEN    = 8'h5B;
	localparam logic [7:0] CH_CLOSE   = 8'h5D;
	localparam logic [7:0] CH_EQUALS  = 8'h3D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_DEL     = 8'h7F;
	localparam logic [7:0] CH_CTL_MAX = 8'h1F;
	localparam logic [7:0] SPACE_SAT  = 8'hFF;

	// parser states
	localparam logic [2:0] ST_IDLE       = 3'd0;
	localparam logic [2:0] ST_COMMENT    = 3'd1;
	localparam logic [2:0] ST_SECTION    = 3'd2;
	localparam logic [2:0] ST_KEY        = 3'd3;
	localparam logic [2:0] ST_AFTER_KEY  = 3'd4;
	localparam logic [2:0] ST_BEFORE_VAL = 3'd5;
	localparam logic [2:0] ST_VALUE      = 3'd6;
	localparam logic [2:0] ST_BAD_LINE   = 3'd7;

	// token kinds
	localparam logic [2:0] TK_SECTION_BYTE = 3'd0;
	localparam logic [2:0] TK_KEY_BYTE     = 3'd1;
	localparam logic [2:0] TK_VALUE_BYTE   = 3'd2;
	localparam logic [2:0] TK_SPACE_RUN    = 3'd3;
	localparam logic [2:0] TK_SECTION_DONE = 3'd4;
	localparam logic [2:0] TK_PROP_DONE    = 3'd5;
	localparam logic [2:0] TK_DISCARD      = 3'd6;
	localparam logic [2:0] TK_TEXT_END     = 3'd7;

	typedef struct packed {
		logic [2:0]       pstate;
		logic [7:0]       pending;
		logic [LEN_W-1:0] len;
		logic             ovf;
	} itt_state_t;

	typedef struct packed {
		logic [2:0] kind;
		logic [7:0] data;
		logic [7:0] run;
		logic       ovf;
	} itt_result_t;

	localparam itt_state_t STATE_RESET = '{pstate: ST_IDLE, pending: 8'd0,
		len: '0, ovf: 1'b0};

	function automatic itt_result_t mk_result(input logic [2:0] kind,
		input logic [7:0] data, input logic [7:0] run, input logic ovf);
		itt_result_t r;
		r.kind = kind;
		r.data = data;
		r.run  = run;
		r.ovf  = ovf;
		return r;
	endfunction

endpackage

`default_nettype wire

### design/itt_step.sv
// Next-state and token generation for one text byte.
`default_nettype none

module itt_step import itt_pkg::*; (
	input  itt_state_t        cur,
	input  logic [7:0]        text_byte,
	input  logic              end_of_text,
	output itt_state_t        nx,
	output itt_result_t       res [RES_MAX],
	output logic [RES_CNT_W-1:0] res_cnt
);

	logic             ctl;
	logic             blank;
	logic [7:0]       pend;
	logic [CMP_W-1:0] pend_w;
	logic [CMP_W-1:0] room;
	logic [CMP_W-1:0] run_n;
	logic [LEN_W-1:0] len_vv;
	logic             fit_cur;
	logic             fit_vv;

	assign ctl     = (text_byte <= CH_CTL_MAX) || (text_byte == CH_DEL);
	assign blank   = (text_byte == CH_SPACE) || (text_byte == CH_TAB);
	// entering a value drops any stale count
	assign pend    = (cur.pstate == ST_BEFORE_VAL) ? 8'd0 : cur.pending;
	assign pend_w  = CMP_W'(pend);
	assign room    = CMP_W'(LEN_LIMIT - cur.len);
	assign run_n   = (pend_w < room) ? pend_w : room;
	assign len_vv  = cur.len + run_n[LEN_W-1:0];
	assign fit_cur = cur.len < LEN_LIMIT;
	assign fit_vv  = len_vv < LEN_LIMIT;

	always_comb begin
		nx      = cur;
		res_cnt = '0;
		res     = '{default: '0};
		case (cur.pstate)
			ST_IDLE: begin
				if (text_byte == CH_COMMENT) begin
					nx.pstate = ST_COMMENT;
				end else if (text_byte == CH_OPEN) begin
					nx = STATE_RESET;
					nx.pstate = ST_SECTION;
				end else if (!blank && text_byte != CH_NEWLINE) begin
					nx = STATE_RESET;
					nx.pstate = ST_KEY;
					if (!ctl) begin
						res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_KEY_BYTE, text_byte,
							8'd0, 1'b0);
						res_cnt = res_cnt + RES_CNT_W'(1);
						nx.len  = LEN_W'(1);
					end
				end
			end
			ST_COMMENT, ST_BAD_LINE: begin
				if (text_byte == CH_NEWLINE)
					nx.pstate = ST_IDLE;
			end
			ST_SECTION: begin
				if (text_byte == CH_CLOSE) begin
					res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_SECTION_DONE, 8'd0, 8'd0,
						cur.ovf);
					res_cnt   = res_cnt + RES_CNT_W'(1);
					nx.pstate = ST_IDLE;
				end else if (text_byte == CH_NEWLINE) begin
					res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_DISCARD, 8'd0, 8'd0, 1'b0);
					res_cnt   = res_cnt + RES_CNT_W'(1);
					nx.pstate = ST_IDLE;
				end else if (!ctl) begin
					if (fit_cur) begin
						res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_SECTION_BYTE, text_byte,
							8'd0, 1'b0);
						res_cnt = res_cnt + RES_CNT_W'(1);
						nx.len  = cur.len + LEN_W'(1);
					end else begin
						nx.ovf = 1'b1;
					end
				end
			end
			ST_KEY: begin
				if (blank) begin
					nx.len    = '0;
					nx.pstate = ST_AFTER_KEY;
				end else if (text_byte == CH_NEWLINE) begin
					res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_DISCARD, 8'd0, 8'd0, 1'b0);
					res_cnt   = res_cnt + RES_CNT_W'(1);
					nx.pstate = ST_IDLE;
				end else if (!ctl) begin
					if (fit_cur) begin
						res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_KEY_BYTE, text_byte,
							8'd0, 1'b0);
						res_cnt = res_cnt + RES_CNT_W'(1);
						nx.len  = cur.len + LEN_W'(1);
					end else begin
						nx.ovf = 1'b1;
					end
				end
			end
			ST_AFTER_KEY: begin
				if (text_byte == CH_EQUALS) begin
					nx.pstate = ST_BEFORE_VAL;
				end else if (text_byte == CH_NEWLINE) begin
					res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_DISCARD, 8'd0, 8'd0, 1'b0);
					res_cnt   = res_cnt + RES_CNT_W'(1);
					nx.pstate = ST_IDLE;
				end else if (!blank) begin
					res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_DISCARD, 8'd0, 8'd0, 1'b0);
					res_cnt   = res_cnt + RES_CNT_W'(1);
					nx.pstate = ST_BAD_LINE;
				end
			end
			ST_BEFORE_VAL, ST_VALUE: begin
				if (text_byte == CH_NEWLINE) begin
					if (cur.pstate == ST_VALUE) begin
						res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_PROP_DONE, 8'd0, 8'd0,
							cur.ovf);
					end else begin
						res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_DISCARD, 8'd0, 8'd0,
							1'b0);
					end
					res_cnt    = res_cnt + RES_CNT_W'(1);
					nx.pending = 8'd0;
					nx.pstate  = ST_IDLE;
				end else if (cur.pstate == ST_VALUE && text_byte == CH_SPACE) begin
					if (cur.pending < SPACE_SAT)
						nx.pending = cur.pending + 8'd1;
					else
						nx.ovf = 1'b1;
				end else if (cur.pstate == ST_VALUE || !blank) begin
					nx.pstate  = ST_VALUE;
					nx.pending = pend;
					if (!ctl) begin
						// flush held spaces, clipped to the room left
						if (pend != 8'd0) begin
							if (run_n < pend_w)
								nx.ovf = 1'b1;
							if (run_n != '0) begin
								res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_SPACE_RUN, 8'd0,
									run_n[7:0], 1'b0);
								res_cnt = res_cnt + RES_CNT_W'(1);
							end
							nx.pending = 8'd0;
						end
						nx.len = len_vv;
						if (fit_vv) begin
							res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_VALUE_BYTE, text_byte,
								8'd0, 1'b0);
							res_cnt = res_cnt + RES_CNT_W'(1);
							nx.len  = len_vv + LEN_W'(1);
						end else begin
							nx.ovf = 1'b1;
						end
					end
				end
			end
			default: begin
				nx = cur;
			end
		endcase

		if (end_of_text) begin
			if (nx.pstate inside {[ST_SECTION:ST_VALUE]}) begin
				res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_DISCARD, 8'd0, 8'd0, 1'b0);
				res_cnt = res_cnt + RES_CNT_W'(1);
			end
			res[res_cnt[RES_IDX_W-1:0]] = mk_result(TK_TEXT_END, 8'd0, 8'd0, 1'b0);
			res_cnt = res_cnt + RES_CNT_W'(1);
			nx      = STATE_RESET;
		end
	end

endmodule

`default_nettype wire

### design/ini_text_tokenizer_core.sv
// INI text tokenizer top level: input register, token step, result buffer.
// Takes INI text one byte per beat and emits tagged tokens (section, key and
// value bytes, value space runs, done and discard markers, text end). A byte
// that yields zero or one token streams at one byte per clock while the output
// accepts; a byte that yields more (up to four tokens) holds the input while
// the result buffer drains one token per accepted beat. Tokens leave from the
// result buffer, which is loaded from the registered input byte. last_of_run
// marks the final token of a byte. Bytes that yield no token pass through
// without waiting for the output side.
`default_nettype none

module ini_text_tokenizer_core import itt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] token_kind,
	output logic [7:0] data_byte,
	output logic [7:0] space_run,
	output logic       overflowed,
	output logic       last_of_run
);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 end_s1;
	itt_state_t           st_q;
	itt_state_t           st_nx;
	itt_result_t          res [RES_MAX];
	logic [RES_CNT_W-1:0] res_cnt;
	itt_result_t          buf_q [RES_MAX];
	logic [RES_CNT_W-1:0] buf_cnt_q;
	logic [RES_IDX_W-1:0] buf_idx_q;
	logic [RES_CNT_W-1:0] cnt_m1;
	logic                 buf_last;
	logic                 buf_free;
	logic                 pop;
	logic                 consume;
	itt_result_t          cur_res;

	itt_step u_step (
		.cur         (st_q),
		.text_byte   (byte_s1),
		.end_of_text (end_s1),
		.nx          (st_nx),
		.res         (res),
		.res_cnt     (res_cnt)
	);

	assign cnt_m1    = buf_cnt_q - RES_CNT_W'(1);
	assign buf_last  = buf_idx_q == cnt_m1[RES_IDX_W-1:0];
	assign out_valid = buf_cnt_q != '0;
	assign pop       = out_valid && out_ready;
	assign buf_free  = !out_valid || (out_ready && buf_last);
	assign consume   = valid_s1 && (res_cnt == '0 || buf_free);
	assign in_ready  = !valid_s1 || consume;

	assign cur_res     = buf_q[buf_idx_q];
	assign token_kind  = cur_res.kind;
	assign data_byte   = cur_res.data;
	assign space_run   = cur_res.run;
	assign overflowed  = cur_res.ovf;
	assign last_of_run = buf_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			st_q      <= STATE_RESET;
			buf_cnt_q <= '0;
			buf_idx_q <= '0;
		end else begin
			if (in_ready)
				valid_s1 <= in_valid;
			if (consume)
				st_q <= st_nx;
			if (consume && res_cnt != '0) begin
				buf_cnt_q <= res_cnt;
				buf_idx_q <= '0;
			end else if (pop) begin
				if (buf_last)
					buf_cnt_q <= '0;
				else
					buf_idx_q <= buf_idx_q + RES_IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= text_byte;
			end_s1  <= end_of_text;
		end
		if (consume && res_cnt != '0)
			buf_q <= res;
	end

endmodule

`default_nettype wire

### design/itt_checker.sv
// Port-level checker for the INI tokenizer, bound to the top level.
`default_nettype none
`include "ini_text_tokenizer_core_assert.svh"

module itt_checker import itt_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] text_byte,
	input logic       end_of_text,
	input logic       out_valid,
	input logic       out_ready,
	input logic [2:0] token_kind,
	input logic [7:0] data_byte,
	input logic [7:0] space_run,
	input logic       overflowed,
	input logic       last_of_run
);

	`ITT_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(token_kind) && $stable(data_byte) && $stable(space_run), "output beat changed while stalled")
	`ITT_ASSERT(a_data_zero, out_valid && token_kind != TK_SECTION_BYTE && token_kind != TK_KEY_BYTE && token_kind != TK_VALUE_BYTE, data_byte == 8'd0, "data_byte set on a marker")
	`ITT_ASSERT(a_run_kind, out_valid, (token_kind == TK_SPACE_RUN) == (space_run != 8'd0), "space_run inconsistent with kind")
	`ITT_ASSERT(a_end_last, out_valid && token_kind == TK_TEXT_END, last_of_run && overflowed == 1'b0, "text end is not the last token")

endmodule

bind ini_text_tokenizer_core itt_checker u_itt_checker (.*);

`default_nettype wire
